// ----- rtl/pdrm_pkg.sv -----
// pdrm_pkg: shared types and constants of the PWM duty-cycle strength meter.
// No dependencies; compiled first.
package pdrm_pkg;

    // Event kind carried by an input beat
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Configuration register map
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    localparam t_cfg_idx CFG_TIMER_PERIOD  = 2'd0;
    localparam t_cfg_idx CFG_TIMEOUT_TICKS = 2'd1;

    localparam t_cfg_data TIMER_PERIOD_RST  = 16'd65535;
    localparam t_cfg_data TIMEOUT_TICKS_RST = 16'd100;

    // Strength percentage
    localparam int PCT_BITS = 7;
    typedef logic [PCT_BITS-1:0] t_pct;
    localparam t_pct FULL_SCALE = 7'd100;
    localparam t_pct PCT_ZERO   = 7'd0;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

endpackage

// ----- rtl/pdrm_if.sv -----
// pdrm_if: valid/ready channel interfaces of the strength meter (event in,
// result out, configuration write). Depends on pdrm_pkg.
interface pdrm_in_if import pdrm_pkg::*; #(
    parameter int CAPTURE_BITS = 16
) ();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [CAPTURE_BITS-1:0] capture_value;
    logic                    pin_level;

    modport source (output valid, func, capture_value, pin_level, input ready);
    modport sink   (input valid, func, capture_value, pin_level, output ready);
endinterface

interface pdrm_out_if import pdrm_pkg::*; ();
    logic valid;
    logic ready;
    t_pct strength_percent;
    logic strength_updated;
    logic timed_out;

    modport source (output valid, strength_percent, strength_updated, timed_out,
                    input ready);
    modport sink   (input valid, strength_percent, strength_updated, timed_out,
                    output ready);
endinterface

interface pdrm_cfg_if import pdrm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/pwm_duty_cycle_rssi_meter.sv -----
// pwm_duty_cycle_rssi_meter: top level of the PWM duty-cycle strength meter.
// Depends on pdrm_pkg, pdrm_if (channel interfaces) and pdrm_div.
//
// Usage:
//   i_in carries one event per beat: a capture edge (func = edge, timer
//   capture and pin level after the edge) or a 1 ms tick (func = tick).
//   o_out returns exactly one result beat per event: the strength percentage
//   after the event, whether the event wrote it, and whether a tick timed out.
//   i_cfg writes timer_period (index 0) or timeout_ticks (index 1); other
//   indexes are ignored. It is always ready; write only while idle.
// Sequence:
//   Ticks and rising edges go from the accept to the push step and back to
//   idle, the result passing through the output register to o_out.
//   A falling edge first runs the bit-serial divider, one numerator bit per
//   cycle over all CAPTURE_BITS + 8 bits of the scaled numerator, then the push step.
//   One event is in work at a time; an event is accepted while the previous
//   result still sits in the output register.
// Reset (synchronous, active low): widths, capture, silence count and
//   strength clear to zero, registers return to 65535 and 100.
// Stall: a stalled o_out holds its beat; the block then waits in its push
//   step with the next result and accepts no new event until it moves.
module pwm_duty_cycle_rssi_meter import pdrm_pkg::*; #(
    parameter int CAPTURE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdrm_in_if.sink     i_in,
    pdrm_out_if.source  o_out,
    pdrm_cfg_if.sink    i_cfg
);
    localparam int W = CAPTURE_BITS + 1;

    t_state                  r_state, n_state;
    t_cfg_data               r_timer_period, n_timer_period;
    t_cfg_data               r_timeout_ticks, n_timeout_ticks;
    logic [CAPTURE_BITS-1:0] r_prev, n_prev;
    logic [W-1:0]            r_low, n_low;
    logic [W-1:0]            r_high, n_high;
    t_cfg_data               r_silence, n_silence;
    t_pct                    r_strength, n_strength;
    logic                    r_res_upd, n_res_upd;
    logic                    r_res_tout, n_res_tout;
    logic                    r_out_valid, n_out_valid;
    t_pct                    r_out_pct;
    logic                    r_out_upd;
    logic                    r_out_tout;

    logic                    in_acc;
    logic                    cfg_acc;
    logic                    out_free;
    logic [W+15:0]           period_wide;
    logic [W-1:0]            period_w;
    logic [W-1:0]            cap_w;
    logic [W-1:0]            prev_w;
    logic [W-1:0]            width;
    logic [W:0]              sum;
    logic [CFG_DATA_BITS:0]  cnt_next;
    logic                    div_start;
    logic                    div_done;
    t_pct                    div_quot;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // pulse width since the previous capture, wrapped by the timer period
    assign period_wide = {{W{1'b0}}, r_timer_period};
    assign period_w    = period_wide[W-1:0];
    assign cap_w       = {1'b0, i_in.capture_value};
    assign prev_w      = {1'b0, r_prev};
    assign width       = (i_in.capture_value > r_prev) ? (cap_w - prev_w)
                                                       : (period_w - prev_w + cap_w);
    assign sum         = {1'b0, width} + {1'b0, r_low};

    // silence counter increment, one bit wider to see the limit crossing
    assign cnt_next = {1'b0, r_silence} + 1'b1;

    assign div_start = (r_state == S_IDLE) && in_acc && (i_in.func == FUNC_EDGE)
                       && !i_in.pin_level && (sum != '0);

    pdrm_div #(
        .WIDTH_BITS (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_low),
        .i_den   (sum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // event sequencer and measurement state
    always_comb begin
        n_state         = r_state;
        n_timer_period  = r_timer_period;
        n_timeout_ticks = r_timeout_ticks;
        n_prev          = r_prev;
        n_low           = r_low;
        n_high          = r_high;
        n_silence       = r_silence;
        n_strength      = r_strength;
        n_res_upd       = r_res_upd;
        n_res_tout      = r_res_tout;

        // configuration writes
        if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_TIMER_PERIOD:  n_timer_period  = i_cfg.data;
                CFG_TIMEOUT_TICKS: n_timeout_ticks = i_cfg.data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_upd  = 1'b0;
                    n_res_tout = 1'b0;
                    n_state    = S_PUSH;
                    if (i_in.func == FUNC_EDGE) begin
                        n_silence = '0;
                        n_prev    = i_in.capture_value;
                        if (i_in.pin_level) begin
                            n_low = width;
                        end else begin
                            n_high    = width;
                            n_res_upd = 1'b1;
                            if (sum == '0) begin
                                n_strength = PCT_ZERO;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                    end else begin
                        if (cnt_next > {1'b0, r_timeout_ticks}) begin
                            n_silence  = r_timeout_ticks;
                            n_strength = i_in.pin_level ? PCT_ZERO : FULL_SCALE;
                            n_res_upd  = 1'b1;
                            n_res_tout = 1'b1;
                        end else begin
                            n_silence = cnt_next[CFG_DATA_BITS-1:0];
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_strength = div_quot;
                    n_state    = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    assign n_out_valid = (r_out_valid && !o_out.ready) || (r_state == S_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_timer_period  <= TIMER_PERIOD_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
            r_prev          <= '0;
            r_low           <= '0;
            r_high          <= '0;
            r_silence       <= '0;
            r_strength      <= PCT_ZERO;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_timer_period  <= n_timer_period;
            r_timeout_ticks <= n_timeout_ticks;
            r_prev          <= n_prev;
            r_low           <= n_low;
            r_high          <= n_high;
            r_silence       <= n_silence;
            r_strength      <= n_strength;
            r_out_valid     <= n_out_valid;
        end
        r_res_upd  <= n_res_upd;
        r_res_tout <= n_res_tout;
        if ((r_state == S_PUSH) && out_free) begin
            r_out_pct  <= r_strength;
            r_out_upd  <= r_res_upd;
            r_out_tout <= r_res_tout;
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign i_cfg.ready            = 1'b1;
    assign o_out.valid            = r_out_valid;
    assign o_out.strength_percent = r_out_pct;
    assign o_out.strength_updated = r_out_upd;
    assign o_out.timed_out        = r_out_tout;

    // a timeout always writes the strength, and only to a rail value
    a_tout_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.timed_out |->
            o_out.strength_updated &&
            (o_out.strength_percent == PCT_ZERO || o_out.strength_percent == FULL_SCALE))
        else $error("timeout beat without a rail strength");

    // an accepted event moves the sequencer out of idle
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after an accepted event");

    // division results arrive only while waiting for them, and never exceed 100
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV) && (div_quot <= FULL_SCALE))
        else $error("unexpected or out-of-range division result");

    // a result is pushed only into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("push step lost its result");

endmodule

// ----- rtl/pdrm_div.sv -----
// pdrm_div: bit-serial restoring divider, floor(num*100/den), one numerator
// bit per cycle. Depends on pdrm_pkg.
module pdrm_div import pdrm_pkg::*; #(
    parameter int WIDTH_BITS = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WIDTH_BITS-1:0] i_num,
    input  logic [WIDTH_BITS:0]   i_den,
    output logic                  o_done,
    output t_pct                  o_quot
);
    // numerator is num*100 < 2^(WIDTH_BITS+7)
    localparam int NB       = WIDTH_BITS + 7;
    localparam int CNT_BITS = $clog2(NB + 1);

    logic [NB-1:0]         r_num, n_num;
    logic [WIDTH_BITS:0]   r_rem, n_rem;
    logic [WIDTH_BITS:0]   r_den, n_den;
    t_pct                  r_quot, n_quot;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;

    logic [NB-1:0]         num_ext;
    logic [NB-1:0]         num_x100;
    logic [WIDTH_BITS+1:0] trial;
    logic [WIDTH_BITS+1:0] diff;
    logic                  fits;

    // num*100 = num*64 + num*32 + num*4
    assign num_ext  = {7'b0, i_num};
    assign num_x100 = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);

    // one restoring step: bring down the next numerator bit
    assign trial = {r_rem, r_num[NB-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = num_x100;
            n_rem  = '0;
            n_den  = i_den;
            n_quot = '0;
            n_cnt  = CNT_BITS'(NB);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num  = {r_num[NB-2:0], 1'b0};
            n_rem  = fits ? diff[WIDTH_BITS:0] : trial[WIDTH_BITS:0];
            n_quot = {r_quot[PCT_BITS-2:0], fits};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // a start never lands on a running division
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // done follows the last step of a running division
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a running division");

    // remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_den)
        else $error("divider remainder out of range");

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench of pwm_duty_cycle_rssi_meter; edge and tick events
// are checked against a cycle-free duty/timeout tracker. Needs pdrm_pkg, pdrm_if.
module tb;
    import pdrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_BITS    = 16;
    localparam int RESET_CYC   = 11;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYC    = 40;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 119;

    // Indexes outside the register map; writes there must be dropped
    localparam t_cfg_idx CFG_IDX_SPARE2 = 2'd2;
    localparam t_cfg_idx CFG_IDX_SPARE3 = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        t_pct pct;
        logic updated;
        logic timed_out;
    } t_reading;

    // Tracks widths, silence and strength; queues one expected reading per event
    class duty_tracker;
        t_cfg_data           period;
        t_cfg_data           limit;
        logic [CAP_BITS-1:0] prev_cap;
        logic [CAP_BITS:0]   low_w;
        logic [CAP_BITS:0]   high_w;
        logic [15:0]         silence;
        t_pct                strength;
        t_reading            expected_readings[$];
        int errors;
        int events;
        int readings;
        int updates;
        int timeouts;

        function new();
            period   = TIMER_PERIOD_RST;
            limit    = TIMEOUT_TICKS_RST;
            prev_cap = '0;
            low_w    = '0;
            high_w   = '0;
            silence  = '0;
            strength = PCT_ZERO;
            errors   = 0;
            events   = 0;
            readings = 0;
            updates  = 0;
            timeouts = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data val);
            if (idx == CFG_TIMER_PERIOD) begin
                period = val;
            end else if (idx == CFG_TIMEOUT_TICKS) begin
                limit = val;
            end
        endfunction

        // Width since the last capture, wrapping through the timer period
        function logic [CAP_BITS:0] width_since(logic [CAP_BITS-1:0] cap);
            logic [CAP_BITS:0] w;
            if (cap > prev_cap) begin
                w = {1'b0, cap} - {1'b0, prev_cap};
            end else begin
                w = {1'b0, period} - {1'b0, prev_cap} + {1'b0, cap};
            end
            return w;
        endfunction

        function t_pct duty_of_widths();
            logic [CAP_BITS+1:0] total;
            logic [31:0]         scaled;
            logic [31:0]         quot;
            total = {1'b0, high_w} + {1'b0, low_w};
            if (total == '0) begin
                return PCT_ZERO;
            end
            scaled = 32'(low_w) * 32'(FULL_SCALE);
            quot   = scaled / 32'(total);
            return t_pct'(quot[PCT_BITS-1:0]);
        endfunction

        function void note_event(logic func, logic [CAP_BITS-1:0] cap, logic pin);
            t_reading          r;
            logic [CAP_BITS:0] w;
            logic [16:0]       nxt;
            r.updated   = 1'b0;
            r.timed_out = 1'b0;
            if (func == FUNC_EDGE) begin
                w       = width_since(cap);
                silence = '0;
                if (pin) begin
                    low_w = w;
                end else begin
                    high_w    = w;
                    strength  = duty_of_widths();
                    r.updated = 1'b1;
                end
                prev_cap = cap;
            end else begin
                nxt = {1'b0, silence} + 17'd1;
                if (nxt > {1'b0, limit}) begin
                    silence     = limit;
                    strength    = pin ? PCT_ZERO : FULL_SCALE;
                    r.updated   = 1'b1;
                    r.timed_out = 1'b1;
                end else begin
                    silence = nxt[15:0];
                end
            end
            r.pct = strength;
            expected_readings.push_back(r);
            events++;
        endfunction

        function void check_result(t_pct pct, logic upd, logic tout);
            t_reading r;
            if (expected_readings.size() == 0) begin
                $error("result beat with nothing expected: pct=%0d upd=%0b tout=%0b",
                       pct, upd, tout);
                errors++;
                return;
            end
            r = expected_readings.pop_front();
            readings++;
            if (r.updated) updates++;
            if (r.timed_out) timeouts++;
            if (pct !== r.pct) begin
                $error("strength_percent: expected %0d, got %0d", r.pct, pct);
                errors++;
            end
            if (upd !== r.updated) begin
                $error("strength_updated: expected %0b, got %0b", r.updated, upd);
                errors++;
            end
            if (tout !== r.timed_out) begin
                $error("timed_out: expected %0b, got %0b", r.timed_out, tout);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdrm_in_if #(.CAPTURE_BITS(CAP_BITS)) in_ch ();
    pdrm_out_if                           out_ch ();
    pdrm_cfg_if                           cfg_ch ();

    pwm_duty_cycle_rssi_meter #(.CAPTURE_BITS(CAP_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    duty_tracker tracker = new();

    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        items_sent     = 0;
    int        quiet_cycles   = 0;
    int        cursor         = 0;
    t_cfg_data cur_period     = TIMER_PERIOD_RST;
    t_cfg_data cur_limit      = TIMEOUT_TICKS_RST;

    always #5 i_clk = ~i_clk;

    // Result-side backpressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Beat monitor: register writes, accepted events, accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                tracker.write_reg(cfg_ch.index, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                tracker.note_event(in_ch.func, in_ch.capture_value, in_ch.pin_level);
            end
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_result(out_ch.strength_percent, out_ch.strength_updated,
                                     out_ch.timed_out);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
                (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic set_idle(t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default:   begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // One event beat; valid stays high into the next call unless it idles
    task automatic send_event(logic func, logic [CAP_BITS-1:0] cap, logic pin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= func;
        in_ch.capture_value <= cap;
        in_ch.pin_level     <= pin;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding reading; the first edge lets
    // the monitor log the last accepted event
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(t_cfg_data period, t_cfg_data limit, bit poke_spare);
        write_reg(CFG_TIMER_PERIOD, period);
        write_reg(CFG_TIMEOUT_TICKS, limit);
        if (poke_spare) begin
            write_reg(CFG_IDX_SPARE2, t_cfg_data'($urandom));
            write_reg(CFG_IDX_SPARE3, t_cfg_data'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        cur_period = period;
        cur_limit  = limit;
        cursor     = 0;
    endtask

    // Next capture of a well-formed waveform, inside the timer range (random for a zero period)
    function automatic logic [CAP_BITS-1:0] advance(int d);
        if (cur_period == '0) begin
            return CAP_BITS'($urandom);
        end
        cursor = (cursor + d) % (int'(cur_period) + 1);
        return cursor[CAP_BITS-1:0];
    endfunction

    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 2000);
        if (r < 95) return $urandom_range(0, int'(cur_period));
        return 0;
    endfunction

    // Mostly pulses and silence bursts, the rest free-form noise
    task automatic gen_traffic(int count);
        int target;
        int r;
        int burst;
        int top;
        logic pin;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_event(FUNC_EDGE, advance(pick_width()), 1'b1);
                send_event(FUNC_EDGE, advance(pick_width()), 1'b0);
                if ($urandom_range(0, 3) == 0) begin
                    send_event(FUNC_TICK, CAP_BITS'($urandom), 1'($urandom));
                end
            end else if (r < 80) begin
                top   = (int'(cur_limit) < 30) ? int'(cur_limit) + 3 : 30;
                burst = $urandom_range(1, top);
                pin   = 1'($urandom);
                repeat (burst) send_event(FUNC_TICK, CAP_BITS'($urandom), pin);
            end else begin
                send_event(1'($urandom), CAP_BITS'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        t_cfg_data period;
        t_cfg_data limit;

        // Known values on every driven block input from time zero
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_EDGE;
        in_ch.capture_value = '0;
        in_ch.pin_level     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_TIMER_PERIOD;
        cfg_ch.data         = '0;

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset state, plain and wrapped widths, full-range captures
        set_idle(IDLE_NONE);
        send_event(FUNC_TICK, 16'h0000, 1'b1);
        send_event(FUNC_EDGE, 16'd100, 1'b1);
        send_event(FUNC_EDGE, 16'd300, 1'b0);
        send_event(FUNC_EDGE, 16'hFFFF, 1'b1);
        send_event(FUNC_EDGE, 16'h0000, 1'b0);
        send_event(FUNC_EDGE, 16'h0000, 1'b1);
        send_event(FUNC_EDGE, 16'hFFFF, 1'b0);

        // Previous capture above the period, then saturation of the silence count
        settle();
        program_regs(16'd1000, 16'd3, 1'b0);
        send_event(FUNC_EDGE, 16'd900, 1'b1);
        send_event(FUNC_EDGE, 16'd100, 1'b0);
        send_event(FUNC_TICK, 16'hFFFF, 1'b0);
        send_event(FUNC_TICK, 16'h0000, 1'b1);
        send_event(FUNC_TICK, 16'h5555, 1'b0);
        send_event(FUNC_TICK, 16'hAAAA, 1'b0);
        send_event(FUNC_TICK, 16'h0000, 1'b1);

        // Raise the limit, count up, then drop it below the count
        settle();
        program_regs(16'd1000, 16'd10, 1'b0);
        repeat (6) send_event(FUNC_TICK, 16'h1234, 1'b1);
        settle();
        program_regs(16'd1000, 16'd2, 1'b0);
        send_event(FUNC_TICK, 16'h0000, 1'b0);

        // Zero period: both widths zero, so the duty sum is zero
        settle();
        program_regs(16'd0, 16'd2, 1'b1);
        send_event(FUNC_EDGE, 16'd100, 1'b1);
        send_event(FUNC_EDGE, 16'd100, 1'b0);
        send_event(FUNC_TICK, 16'hFFFF, 1'b1);

        // Random phases over register settings and idle patterns
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin period = 16'hFFFF; limit = TIMEOUT_TICKS_RST; end
                1:       begin period = 16'h0000; limit = 16'h0000; end
                2:       begin period = 16'hFFFF; limit = 16'hFFFF; end
                3:       begin period = t_cfg_data'($urandom);
                               limit = t_cfg_data'($urandom_range(1, 20)); end
                4:       begin period = 16'd1000; limit = 16'd5; end
                5:       begin period = t_cfg_data'($urandom); limit = 16'h0000; end
                6:       begin period = t_cfg_data'($urandom);
                               limit = t_cfg_data'($urandom); end
                default: begin period = 16'd20000; limit = 16'd1; end
            endcase
            settle();
            set_idle(t_idle_mode'(p % 4));
            program_regs(period, limit, (p == 3) || (p == 6));
            gen_traffic(PHASE_ITEMS);
        end

        settle();
        set_idle(IDLE_NONE);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Run covered %0d events and %0d result beats over %0d phases;",
                 tracker.events, tracker.readings, PHASES);
        $display("%0d strength writes, %0d of them forced by silence timeouts.",
                 tracker.updates, tracker.timeouts);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
